### src/line_segment_depth_clipper_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the line segment depth clipper
// ---------------------------------------------------------------------------
`ifndef LINE_SEGMENT_DEPTH_CLIPPER_CORE_DEFINES_SVH
`define LINE_SEGMENT_DEPTH_CLIPPER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// check a property on every clock edge outside reset
`define LSDC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lsdc: assertion failed");
// check that an expression is never true outside reset
`define LSDC_ASSERT_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("lsdc: forbidden condition seen");
`else
`define LSDC_ASSERT(lbl, prop)
`define LSDC_ASSERT_NEVER(lbl, expr)
`endif

`endif

### src/lsdc_pkg.sv
// ---------------------------------------------------------------------------
// lsdc_pkg
// Constants, stage map and pipeline word type of the depth clipper.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lsdc_pkg;

    localparam int COORD_W = 32;
    localparam int FRAC_W  = 8;
    localparam int T_FRAC  = 16;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int REM_W   = COORD_W + 2;
    localparam int PROD_W  = T_FRAC + 2 + DIFF_W;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_FRONT_PLANE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BACK_PLANE  = CFG_IDX_W'(1);

    localparam logic signed [COORD_W-1:0] FRONT_RESET = COORD_W'(-40 * (1 << FRAC_W));
    localparam logic signed [COORD_W-1:0] BACK_RESET  = COORD_W'(-3500 * (1 << FRAC_W));

    // stage map
    localparam int ST_CLASS  = 0;
    localparam int ST_PREP   = 1;
    localparam int ST_DINIT  = 2;
    localparam int ST_DSTEP0 = 3;
    localparam int ST_MUL1   = ST_DSTEP0 + T_FRAC;
    localparam int ST_ADD1   = ST_MUL1 + 1;
    localparam int ST_SUB2   = ST_ADD1 + 1;
    localparam int ST_MUL2   = ST_SUB2 + 1;
    localparam int ST_ADD2   = ST_MUL2 + 1;
    localparam int ST_OUT    = ST_ADD2 + 1;
    localparam int NUM_STAGES = ST_OUT + 1;

    typedef struct packed {
        logic                      near_end;
        logic                      reject;
        logic                      move1;
        logic                      move2;
        logic signed [COORD_W-1:0] xn;
        logic signed [COORD_W-1:0] yn;
        logic signed [COORD_W-1:0] zn;
        logic signed [COORD_W-1:0] xf;
        logic signed [COORD_W-1:0] yf;
        logic signed [COORD_W-1:0] zf;
        logic [DIFF_W-1:0]         num1;
        logic [DIFF_W-1:0]         den1;
        logic [DIFF_W-1:0]         num2;
        logic [DIFF_W-1:0]         den2;
        logic                      sat1;
        logic                      sat2;
        logic [REM_W-1:0]          r1;
        logic [REM_W-1:0]          r2;
        logic [T_FRAC-1:0]         q1;
        logic [T_FRAC-1:0]         q2;
        logic signed [DIFF_W-1:0]  dx;
        logic signed [DIFF_W-1:0]  dy;
        logic signed [PROD_W-1:0]  px;
        logic signed [PROD_W-1:0]  py;
    } item_t;

endpackage

`default_nettype wire

### src/lsdc_seg_if.sv
// ---------------------------------------------------------------------------
// lsdc_seg_if
// Input channel: one 3D segment per word; output channel: visible flag and clipped segment.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lsdc_seg_if;
    logic                              valid;
    logic                              ready;
    logic signed [lsdc_pkg::COORD_W-1:0] start_x;
    logic signed [lsdc_pkg::COORD_W-1:0] start_y;
    logic signed [lsdc_pkg::COORD_W-1:0] start_z;
    logic signed [lsdc_pkg::COORD_W-1:0] end_x;
    logic signed [lsdc_pkg::COORD_W-1:0] end_y;
    logic signed [lsdc_pkg::COORD_W-1:0] end_z;

    modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                    input ready);
    modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  output ready);
endinterface

interface lsdc_clip_if;
    logic                              valid;
    logic                              ready;
    logic                              visible;
    logic signed [lsdc_pkg::COORD_W-1:0] clipped_start_x;
    logic signed [lsdc_pkg::COORD_W-1:0] clipped_start_y;
    logic signed [lsdc_pkg::COORD_W-1:0] clipped_start_z;
    logic signed [lsdc_pkg::COORD_W-1:0] clipped_end_x;
    logic signed [lsdc_pkg::COORD_W-1:0] clipped_end_y;
    logic signed [lsdc_pkg::COORD_W-1:0] clipped_end_z;

    modport source (output valid, visible, clipped_start_x, clipped_start_y,
                    clipped_start_z, clipped_end_x, clipped_end_y, clipped_end_z,
                    input ready);
    modport sink (input valid, visible, clipped_start_x, clipped_start_y,
                  clipped_start_z, clipped_end_x, clipped_end_y, clipped_end_z,
                  output ready);
endinterface

`default_nettype wire

### src/lsdc_div_step.sv
// ---------------------------------------------------------------------------
// lsdc_div_step
// One restoring division step: shift the remainder, subtract if it fits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsdc_div_step (
    input  wire logic [lsdc_pkg::REM_W-1:0]  rem,
    input  wire logic [lsdc_pkg::DIFF_W-1:0] den,
    input  wire logic [lsdc_pkg::T_FRAC-1:0] quo,
    output logic      [lsdc_pkg::REM_W-1:0]  rem_out,
    output logic      [lsdc_pkg::T_FRAC-1:0] quo_out
);

    logic [lsdc_pkg::REM_W-1:0] shifted;
    logic [lsdc_pkg::REM_W-1:0] den_ext;

    always_comb
    begin
        shifted = {rem[lsdc_pkg::REM_W-2:0], 1'b0};
        den_ext = {1'b0, den};
        if (shifted >= den_ext)
        begin
            rem_out = shifted - den_ext;
            quo_out = {quo[lsdc_pkg::T_FRAC-2:0], 1'b1};
        end
        else
        begin
            rem_out = shifted;
            quo_out = {quo[lsdc_pkg::T_FRAC-2:0], 1'b0};
        end
    end

endmodule

`default_nettype wire

### src/line_segment_depth_clipper_core.sv
// ---------------------------------------------------------------------------
// line_segment_depth_clipper_core
// Clips one 3D segment per word against a front and a back depth plane.
// ---------------------------------------------------------------------------
// Usage:
//   segment : valid/ready input, one segment (start and end point, Q23.8).
//   result  : valid/ready output, visible flag and the clipped end points.
//   cfg_*   : write port for the front plane (index 0) and back plane
//             (index 1); write only while no segment is in flight.
// Throughput is one segment per cycle while the receiver is ready; the
// pipeline depth is set by the 16-step restoring divider that forms both
// interpolation ratios side by side, followed by two multiply and add
// steps in turn.
// Every stage holds a valid bit and advances when it is empty or the stage
// after it advances, so bubbles close up while the receiver stalls and the
// input keeps accepting until the pipe is full. Nothing is dropped.
// The ordered plane pair is held in registers loaded from the plane registers.
// Reset empties the pipe and loads the planes with -40.0 and -3500.0.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "line_segment_depth_clipper_core_defines.svh"

module line_segment_depth_clipper_core (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write,
    input  wire logic [lsdc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [lsdc_pkg::COORD_W-1:0]        cfg_data,
    lsdc_seg_if.sink                                 segment,
    lsdc_clip_if.source                              result
);

    localparam int N = lsdc_pkg::NUM_STAGES;
    localparam int W = lsdc_pkg::COORD_W;
    localparam int D = lsdc_pkg::DIFF_W;
    localparam int TF = lsdc_pkg::T_FRAC;

    logic signed [W-1:0] front_plane_reg, back_plane_reg;
    logic signed [W-1:0] hi_plane_reg, lo_plane_reg;
    logic signed [W-1:0] hi_plane_next, lo_plane_next;

    lsdc_pkg::item_t stg_reg  [N];
    lsdc_pkg::item_t stg_next [N];
    logic [N-1:0]    vld_reg;
    logic [N-1:0]    vld_next;
    logic [N:0]      adv;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_plane_reg <= lsdc_pkg::FRONT_RESET;
            back_plane_reg  <= lsdc_pkg::BACK_RESET;
            hi_plane_reg    <= lsdc_pkg::FRONT_RESET;
            lo_plane_reg    <= lsdc_pkg::BACK_RESET;
        end
        else
        begin
            if (cfg_write && cfg_index == lsdc_pkg::REG_FRONT_PLANE)
                front_plane_reg <= cfg_data;
            if (cfg_write && cfg_index == lsdc_pkg::REG_BACK_PLANE)
                back_plane_reg <= cfg_data;
            hi_plane_reg <= hi_plane_next;
            lo_plane_reg <= lo_plane_next;
        end
    end

    // front must be the larger depth: swap if given in reverse
    always_comb
    begin
        if (front_plane_reg < back_plane_reg)
        begin
            hi_plane_next = back_plane_reg;
            lo_plane_next = front_plane_reg;
        end
        else
        begin
            hi_plane_next = front_plane_reg;
            lo_plane_next = back_plane_reg;
        end
    end

    // stall chain: a stage advances when empty or when its successor advances
    always_comb
    begin
        adv[N] = result.ready;
        for (int k = N - 1; k >= 0; k--)
            adv[k] = ~vld_reg[k] | adv[k+1];
    end

    always_comb
    begin
        vld_next[0] = adv[0] ? segment.valid : vld_reg[0];
        for (int k = 1; k < N; k++)
            vld_next[k] = adv[k] ? vld_reg[k-1] : vld_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < N; k++)
            if (adv[k])
                stg_reg[k] <= stg_next[k];
    end

    // classify and pick the near end (larger depth)
    always_comb
    begin
        logic between;
        logic sel;
        stg_next[lsdc_pkg::ST_CLASS] = '0;
        between = segment.start_z < hi_plane_reg && segment.start_z > lo_plane_reg &&
                  segment.end_z < hi_plane_reg && segment.end_z > lo_plane_reg;
        sel = segment.start_z < segment.end_z;
        stg_next[lsdc_pkg::ST_CLASS].reject = !between &&
            ((segment.start_z > hi_plane_reg && segment.end_z > hi_plane_reg) ||
             (segment.start_z < lo_plane_reg && segment.end_z < lo_plane_reg));
        stg_next[lsdc_pkg::ST_CLASS].near_end = sel;
        stg_next[lsdc_pkg::ST_CLASS].xn = sel ? segment.end_x : segment.start_x;
        stg_next[lsdc_pkg::ST_CLASS].yn = sel ? segment.end_y : segment.start_y;
        stg_next[lsdc_pkg::ST_CLASS].zn = sel ? segment.end_z : segment.start_z;
        stg_next[lsdc_pkg::ST_CLASS].xf = sel ? segment.start_x : segment.end_x;
        stg_next[lsdc_pkg::ST_CLASS].yf = sel ? segment.start_y : segment.end_y;
        stg_next[lsdc_pkg::ST_CLASS].zf = sel ? segment.start_z : segment.end_z;
    end

    // move decisions, ratio operands and near-to-far offsets
    always_comb
    begin
        lsdc_pkg::item_t it;
        logic signed [W-1:0] zn1;
        logic m1;
        it = stg_reg[lsdc_pkg::ST_CLASS];
        m1 = it.zn > hi_plane_reg && it.zn != it.zf;
        zn1 = m1 ? hi_plane_reg : it.zn;
        it.move1 = m1;
        it.move2 = it.zf < lo_plane_reg && zn1 != it.zf;
        it.num1 = {it.zn[W-1], it.zn} - {hi_plane_reg[W-1], hi_plane_reg};
        it.den1 = {it.zn[W-1], it.zn} - {it.zf[W-1], it.zf};
        it.num2 = {zn1[W-1], zn1} - {lo_plane_reg[W-1], lo_plane_reg};
        it.den2 = {zn1[W-1], zn1} - {it.zf[W-1], it.zf};
        it.dx = {it.xf[W-1], it.xf} - {it.xn[W-1], it.xn};
        it.dy = {it.yf[W-1], it.yf} - {it.yn[W-1], it.yn};
        it.zn = zn1;
        stg_next[lsdc_pkg::ST_PREP] = it;
    end

    // ratio of one or more saturates; otherwise start the divide
    always_comb
    begin
        lsdc_pkg::item_t it;
        it = stg_reg[lsdc_pkg::ST_PREP];
        it.sat1 = it.num1 >= it.den1;
        it.sat2 = it.num2 >= it.den2;
        it.r1 = {1'b0, it.num1};
        it.r2 = {1'b0, it.num2};
        it.q1 = '0;
        it.q2 = '0;
        stg_next[lsdc_pkg::ST_DINIT] = it;
    end

    for (genvar g = 0; g < TF; g++)
    begin : g_div
        logic [lsdc_pkg::REM_W-1:0] r1_out, r2_out;
        logic [TF-1:0]              q1_out, q2_out;

        lsdc_div_step u_step1 (
            .rem     (stg_reg[lsdc_pkg::ST_DINIT+g].r1),
            .den     (stg_reg[lsdc_pkg::ST_DINIT+g].den1),
            .quo     (stg_reg[lsdc_pkg::ST_DINIT+g].q1),
            .rem_out (r1_out),
            .quo_out (q1_out)
        );

        lsdc_div_step u_step2 (
            .rem     (stg_reg[lsdc_pkg::ST_DINIT+g].r2),
            .den     (stg_reg[lsdc_pkg::ST_DINIT+g].den2),
            .quo     (stg_reg[lsdc_pkg::ST_DINIT+g].q2),
            .rem_out (r2_out),
            .quo_out (q2_out)
        );

        always_comb
        begin
            lsdc_pkg::item_t it;
            it = stg_reg[lsdc_pkg::ST_DINIT+g];
            it.r1 = r1_out;
            it.q1 = q1_out;
            it.r2 = r2_out;
            it.q2 = q2_out;
            stg_next[lsdc_pkg::ST_DSTEP0+g] = it;
        end
    end

    // near end offsets scaled by the first ratio
    always_comb
    begin
        lsdc_pkg::item_t it;
        logic [TF:0] t;
        it = stg_reg[lsdc_pkg::ST_MUL1-1];
        t = it.sat1 ? {1'b1, {TF{1'b0}}} : {1'b0, it.q1};
        it.px = $signed({1'b0, t}) * it.dx;
        it.py = $signed({1'b0, t}) * it.dy;
        stg_next[lsdc_pkg::ST_MUL1] = it;
    end

    always_comb
    begin
        lsdc_pkg::item_t it;
        logic signed [lsdc_pkg::PROD_W-1:0] sx, sy;
        logic signed [D-1:0] ax, ay;
        it = stg_reg[lsdc_pkg::ST_MUL1];
        sx = it.px >>> TF;
        sy = it.py >>> TF;
        ax = {it.xn[W-1], it.xn} + sx[D-1:0];
        ay = {it.yn[W-1], it.yn} + sy[D-1:0];
        if (it.move1)
        begin
            it.xn = ax[W-1:0];
            it.yn = ay[W-1:0];
        end
        stg_next[lsdc_pkg::ST_ADD1] = it;
    end

    // far end interpolates from the clipped near end
    always_comb
    begin
        lsdc_pkg::item_t it;
        it = stg_reg[lsdc_pkg::ST_ADD1];
        it.dx = {it.xf[W-1], it.xf} - {it.xn[W-1], it.xn};
        it.dy = {it.yf[W-1], it.yf} - {it.yn[W-1], it.yn};
        stg_next[lsdc_pkg::ST_SUB2] = it;
    end

    always_comb
    begin
        lsdc_pkg::item_t it;
        logic [TF:0] t;
        it = stg_reg[lsdc_pkg::ST_SUB2];
        t = it.sat2 ? {1'b1, {TF{1'b0}}} : {1'b0, it.q2};
        it.px = $signed({1'b0, t}) * it.dx;
        it.py = $signed({1'b0, t}) * it.dy;
        stg_next[lsdc_pkg::ST_MUL2] = it;
    end

    always_comb
    begin
        lsdc_pkg::item_t it;
        logic signed [lsdc_pkg::PROD_W-1:0] sx, sy;
        logic signed [D-1:0] ax, ay;
        it = stg_reg[lsdc_pkg::ST_MUL2];
        sx = it.px >>> TF;
        sy = it.py >>> TF;
        ax = {it.xn[W-1], it.xn} + sx[D-1:0];
        ay = {it.yn[W-1], it.yn} + sy[D-1:0];
        if (it.move2)
        begin
            it.xf = ax[W-1:0];
            it.yf = ay[W-1:0];
            it.zf = lo_plane_reg;
        end
        stg_next[lsdc_pkg::ST_ADD2] = it;
    end

    // restore start/end order; a rejected word carries zeros
    always_comb
    begin
        lsdc_pkg::item_t it;
        lsdc_pkg::item_t ot;
        it = stg_reg[lsdc_pkg::ST_ADD2];
        ot = it;
        if (it.reject)
        begin
            ot.xn = '0;
            ot.yn = '0;
            ot.zn = '0;
            ot.xf = '0;
            ot.yf = '0;
            ot.zf = '0;
        end
        else if (it.near_end)
        begin
            ot.xn = it.xf;
            ot.yn = it.yf;
            ot.zn = it.zf;
            ot.xf = it.xn;
            ot.yf = it.yn;
            ot.zf = it.zn;
        end
        stg_next[lsdc_pkg::ST_OUT] = ot;
    end

    assign segment.ready          = adv[0];
    assign result.valid           = vld_reg[N-1];
    assign result.visible         = ~stg_reg[N-1].reject;
    assign result.clipped_start_x = stg_reg[N-1].xn;
    assign result.clipped_start_y = stg_reg[N-1].yn;
    assign result.clipped_start_z = stg_reg[N-1].zn;
    assign result.clipped_end_x   = stg_reg[N-1].xf;
    assign result.clipped_end_y   = stg_reg[N-1].yf;
    assign result.clipped_end_z   = stg_reg[N-1].zf;

    `LSDC_ASSERT(a_accept_fills, segment.valid && segment.ready |=> vld_reg[0])
    `LSDC_ASSERT(a_reject_zero, result.valid && !result.visible |-> result.clipped_start_x == '0 && result.clipped_start_z == '0 && result.clipped_end_y == '0 && result.clipped_end_z == '0)
    `LSDC_ASSERT_NEVER(a_start_out_of_planes, result.valid && result.visible && (result.clipped_start_z > hi_plane_reg || result.clipped_start_z < lo_plane_reg))
    `LSDC_ASSERT_NEVER(a_end_out_of_planes, result.valid && result.visible && (result.clipped_end_z > hi_plane_reg || result.clipped_end_z < lo_plane_reg))

endmodule

`default_nettype wire
